>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/fpbc_pkg.sv
// ---------------------------------------------------------------------------
// fpbc_pkg
// constants and types of the front panel button controller
// ---------------------------------------------------------------------------
package fpbc_pkg;

   localparam int IDLE_WIDTH_DEFAULT = 16;
   localparam int RSP_IDLE_W = 16;
   localparam int CFG_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 8'd60;
   localparam logic [CFG_W-1:0] TPS_RESET = 8'd20;
   localparam logic [CFG_W-1:0] PRESS_MAX = 8'd255;

   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SEC = 1'd1;

   typedef logic [1:0] screen_type;
   typedef logic [1:0] tone_type;

   localparam screen_type SCREEN_HOME = 2'd0;
   localparam screen_type SCREEN_CODE = 2'd1;
   localparam screen_type SCREEN_GAME = 2'd2;
   localparam screen_type SCREEN_UNUSED = 2'd3;

   localparam tone_type TONE_NONE = 2'd0;
   localparam tone_type TONE_CHIRP = 2'd1;
   localparam tone_type TONE_SIREN = 2'd2;

endpackage

>>> src/fpbc_channels.sv
// ---------------------------------------------------------------------------
// fpbc channels
// valid/ready channels for poll tick items and result items
// ---------------------------------------------------------------------------
interface fpbc_req_if;
   import fpbc_pkg::*;

   logic valid;
   logic ready;
   logic power_button_level;
   logic screen_button_level;
   logic action_button_level;
   logic alarm_request;

   modport source (
      output valid,
      input  ready,
      output power_button_level,
      output screen_button_level,
      output action_button_level,
      output alarm_request
   );

   modport sink (
      input  valid,
      output ready,
      input  power_button_level,
      input  screen_button_level,
      input  action_button_level,
      input  alarm_request
   );
endinterface

interface fpbc_rsp_if;
   import fpbc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  shutdown_pulse;
   screen_type            screen_index;
   logic                  jump_pulse;
   logic                  alarm_on;
   logic [RSP_IDLE_W-1:0] idle_seconds;
   tone_type              tone_code;

   modport source (
      output valid,
      input  ready,
      output shutdown_pulse,
      output screen_index,
      output jump_pulse,
      output alarm_on,
      output idle_seconds,
      output tone_code
   );

   modport sink (
      input  valid,
      output ready,
      input  shutdown_pulse,
      input  screen_index,
      input  jump_pulse,
      input  alarm_on,
      input  idle_seconds,
      input  tone_code
   );
endinterface

>>> src/front_panel_button_controller_unit.sv
// ---------------------------------------------------------------------------
// front panel button controller
// per poll tick: long press shutdown, screen cycling, alarm and jump, idle timer
// ---------------------------------------------------------------------------
// channel   direction  handshake          contents
// req_ch    in         valid/ready        three button levels, alarm request
// rsp_ch    out        valid/ready        pulses, screen, alarm, idle, tone
// csr_*     in         write enable only  long press ticks, ticks per second
//
// one item per cycle while rsp_ch is not stalled; a tick's result appears in the cycle after acceptance
// the result register is the only stage: req_ch is ready while it is empty
// or being taken, so a stalled rsp_ch stalls req_ch
// synchronous reset restores the register defaults and the tick state
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module front_panel_button_controller_unit #(
   parameter int IDLE_WIDTH = fpbc_pkg::IDLE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   fpbc_req_if.sink                         req_ch,
   fpbc_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [fpbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpbc_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import fpbc_pkg::*;

   logic [CFG_W-1:0]      long_press_ff;
   logic [CFG_W-1:0]      tps_ff;
   logic [CFG_W-1:0]      press_count_ff, press_count_in;
   logic                  last_scr_ff, last_act_ff;
   screen_type            screen_ff, screen_in;
   logic                  alarm_ff, alarm_in;
   logic [CFG_W-1:0]      prescale_ff, prescale_in;
   logic [IDLE_WIDTH-1:0] idle_ff, idle_in;

   logic                  rsp_valid_ff;
   logic                  shutdown_ff, shutdown_in;
   logic                  jump_ff, jump_in;
   tone_type              tone_ff, tone_in;
   logic [RSP_IDLE_W-1:0] idle_out_ff, idle_out_in;

   logic                  accept;
   logic                  alarm_set;
   logic [CFG_W-1:0]      press_inc;
   logic                  scr_edge, act_edge;
   logic [IDLE_WIDTH-1:0] idle_cleared;
   logic [CFG_W-1:0]      prescale_inc;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      alarm_set = alarm_ff || req_ch.alarm_request;

      // long press on the power button
      press_inc = (press_count_ff < PRESS_MAX) ? press_count_ff + 8'd1 : press_count_ff;
      shutdown_in = 1'b0;
      if (req_ch.power_button_level) begin
         press_count_in = '0;
      end else if (press_inc > long_press_ff) begin
         press_count_in = '0;
         shutdown_in = 1'b1;
      end else begin
         press_count_in = press_inc;
      end

      // screen cycling
      scr_edge = !req_ch.screen_button_level && last_scr_ff;
      screen_in = screen_ff;
      if (scr_edge) begin
         case (screen_ff)
            SCREEN_HOME:   screen_in = SCREEN_CODE;
            SCREEN_CODE:   screen_in = SCREEN_GAME;
            default:       screen_in = SCREEN_HOME;
         endcase
      end

      // action button: clear alarm or jump
      act_edge = !req_ch.action_button_level && last_act_ff;
      alarm_in = alarm_set;
      jump_in = 1'b0;
      if (act_edge) begin
         if (alarm_set) begin
            alarm_in = 1'b0;
         end else if (screen_in == SCREEN_GAME) begin
            jump_in = 1'b1;
         end
      end

      if (alarm_in) begin
         tone_in = TONE_SIREN;
      end else if (jump_in) begin
         tone_in = TONE_CHIRP;
      end else begin
         tone_in = TONE_NONE;
      end

      // idle timer
      idle_cleared = (scr_edge || act_edge || alarm_in) ? '0 : idle_ff;
      prescale_inc = prescale_ff + 8'd1;
      if (prescale_inc >= tps_ff) begin
         prescale_in = '0;
         idle_in = (&idle_cleared) ? idle_cleared : idle_cleared + IDLE_WIDTH'(1);
      end else begin
         prescale_in = prescale_inc;
         idle_in = idle_cleared;
      end
   end

   generate
      if (IDLE_WIDTH > RSP_IDLE_W) begin : g_idle_sat
         assign idle_out_in = (|idle_in[IDLE_WIDTH-1:RSP_IDLE_W]) ? '1
                                                                  : idle_in[RSP_IDLE_W-1:0];
      end else if (IDLE_WIDTH == RSP_IDLE_W) begin : g_idle_same
         assign idle_out_in = idle_in;
      end else begin : g_idle_ext
         assign idle_out_in = {{(RSP_IDLE_W-IDLE_WIDTH){1'b0}}, idle_in};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RESET;
         tps_ff <= TPS_RESET;
         press_count_ff <= '0;
         last_scr_ff <= 1'b1;
         last_act_ff <= 1'b1;
         screen_ff <= SCREEN_HOME;
         alarm_ff <= 1'b0;
         prescale_ff <= '0;
         idle_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LONG_PRESS:    long_press_ff <= csr_wr_data;
               CSR_TICKS_PER_SEC: tps_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (accept) begin
            press_count_ff <= press_count_in;
            last_scr_ff <= req_ch.screen_button_level;
            last_act_ff <= req_ch.action_button_level;
            screen_ff <= screen_in;
            alarm_ff <= alarm_in;
            prescale_ff <= prescale_in;
            idle_ff <= idle_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         shutdown_ff <= shutdown_in;
         jump_ff <= jump_in;
         tone_ff <= tone_in;
         idle_out_ff <= idle_out_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.shutdown_pulse = shutdown_ff;
   assign rsp_ch.screen_index = screen_ff;
   assign rsp_ch.jump_pulse = jump_ff;
   assign rsp_ch.alarm_on = alarm_ff;
   assign rsp_ch.idle_seconds = idle_out_ff;
   assign rsp_ch.tone_code = tone_ff;

   `ASSERT_ALWAYS(a_screen_code, clock, reset, screen_ff != SCREEN_UNUSED)
   `ASSERT_IMPLIES(a_no_jump_in_alarm, clock, reset, rsp_valid_ff && jump_ff, !alarm_ff)
   `ASSERT_IMPLIES(a_alarm_siren, clock, reset, rsp_valid_ff && alarm_ff, tone_ff == TONE_SIREN)
   `ASSERT_IMPLIES(a_alarm_idle, clock, reset, rsp_valid_ff && alarm_ff, idle_ff <= IDLE_WIDTH'(1))
   `ASSERT_NEXT(a_release_clears, clock, reset, accept && req_ch.power_button_level, press_count_ff == '0)

endmodule
